// File: rtl/first_fit_coalescing_allocator_unit_defines.svh
// assertion macros for the first-fit coalescing allocator
// used by rtl modules that check their own control logic; expects clk and rst_n in scope
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FFCA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("allocator check failed");
`define FFCA_NEVER(lbl, expr) \
    `FFCA_ASSERT(lbl, !(expr))
`else
`define FFCA_ASSERT(lbl, prop)
`define FFCA_NEVER(lbl, expr)
`endif
`endif

// File: rtl/ffca_pkg.sv
// types, codes and sizing constants for the first-fit coalescing allocator
// no dependencies
`default_nettype none
package ffca_pkg;

    localparam int ADDR_BITS    = 48;
    localparam int FREE_ENTRIES = 64;
    localparam int USED_ENTRIES = 64;
    localparam int ALIGN_LOG2   = 6;
    localparam int MAX_ENTRIES  = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
    localparam int FREE_IDX_W   = $clog2(FREE_ENTRIES);
    localparam int USED_IDX_W   = $clog2(USED_ENTRIES);
    localparam int IDX_W        = $clog2(MAX_ENTRIES);
    localparam int SCAN_W       = $clog2(MAX_ENTRIES + 1);

    typedef logic [ADDR_BITS-1:0] addr_t;

    localparam logic [1:0] OP_INIT     = 2'd0;
    localparam logic [1:0] OP_ALLOC    = 2'd1;
    localparam logic [1:0] OP_FREE     = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOSPACE = 3'd1;
    localparam logic [2:0] ST_UNKNOWN = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_BAD     = 3'd4;

    localparam logic CFG_POOL_BASE = 1'b0;
    localparam logic CFG_POOL_LEN  = 1'b1;

    typedef struct packed {
        logic [1:0] opcode;
        addr_t      request_size;
        addr_t      block_addr;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        addr_t      result_addr;
        addr_t      granted_size;
    } rsp_t;

    typedef struct packed {
        addr_t base;
        addr_t len;
    } entry_t;

    function automatic rsp_t mk_rsp(logic [2:0] st, addr_t a, addr_t sz);
        rsp_t r;
        r.status       = st;
        r.result_addr  = a;
        r.granted_size = sz;
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/first_fit_coalescing_allocator_unit.sv
// first-fit pool allocator with coalescing free, top level
// depends on ffca_pkg and first_fit_coalescing_allocator_unit_defines.svh
//
// usage: one request transfer on req (valid/ready) gives exactly one response
// transfer on rsp (valid/ready). opcode init clears both tables and builds one
// free chunk from the pool base and pool length registers (or answers bad for
// a zero length), alloc rounds up to 64 bytes and carves the lowest-addressed
// fitting chunk from its high end, free returns a block and merges it with
// touching free chunks. config is a plain write port (cfg_we, cfg_idx,
// cfg_data), written when idle. each table holds 64 entries and is walked at
// most once per request through its single memory read port, one entry per
// cycle. requests rejected at acceptance answer in the cycle after acceptance.
// one request is in flight at a time; req_ready is low from acceptance until
// the response has been transferred and rises the cycle after, so a stalled
// receiver holds off new requests. reset empties both tables and zeroes the
// config registers; no clearing pass is needed.
`default_nettype none
`include "first_fit_coalescing_allocator_unit_defines.svh"
module first_fit_coalescing_allocator_unit
    import ffca_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic  cfg_idx,
    input  wire addr_t cfg_data,
    input  wire logic  req_valid,
    output logic       req_ready,
    input  wire req_t  req,
    output logic       rsp_valid,
    input  wire logic  rsp_ready,
    output rsp_t       rsp
);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_INIT    = 11'b000_0000_0010,
        S_ASCAN   = 11'b000_0000_0100,
        S_ACALC   = 11'b000_0000_1000,
        S_AUSED   = 11'b000_0001_0000,
        S_ACOMMIT = 11'b000_0010_0000,
        S_FUSED   = 11'b000_0100_0000,
        S_FSCAN   = 11'b000_1000_0000,
        S_FPREV   = 11'b001_0000_0000,
        S_FNEXT   = 11'b010_0000_0000,
        S_FCOMMIT = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    addr_t pool_base_reg, pool_len_reg;

    entry_t free_mem [FREE_ENTRIES];
    entry_t used_mem [USED_ENTRIES];
    entry_t free_rd_reg, used_rd_reg;
    logic [FREE_ENTRIES-1:0] free_valid_reg, free_valid_next;
    logic [USED_ENTRIES-1:0] used_valid_reg, used_valid_next;

    logic                  free_we, used_we;
    logic [FREE_IDX_W-1:0] free_waddr;
    logic [USED_IDX_W-1:0] used_waddr;
    entry_t                free_wdata, used_wdata;

    logic [SCAN_W-1:0] scan_idx_reg, scan_idx_next, scan_limit;
    logic              pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]  pipe_idx_reg, pipe_idx_next;
    logic              scan_active, scan_done;

    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg, rsp_next;

    addr_t a_reg, a_next;
    addr_t rounded_reg, rounded_next;
    addr_t ulen_reg, ulen_next;
    addr_t ptr_reg, ptr_next;
    addr_t total_reg, total_next;

    logic  best_found_reg, best_found_next;
    logic [FREE_IDX_W-1:0] best_idx_reg, best_idx_next;
    addr_t best_base_reg, best_base_next, best_len_reg, best_len_next;

    logic  prev_found_reg, prev_found_next;
    logic [FREE_IDX_W-1:0] prev_idx_reg, prev_idx_next;
    addr_t prev_base_reg, prev_base_next, prev_len_reg, prev_len_next;

    logic  next_found_reg, next_found_next;
    logic [FREE_IDX_W-1:0] next_idx_reg, next_idx_next;
    addr_t next_base_reg, next_base_next, next_len_reg, next_len_next;

    logic  same_found_reg, same_found_next;
    logic [FREE_IDX_W-1:0] same_idx_reg, same_idx_next;
    logic  fempty_found_reg, fempty_found_next;
    logic [FREE_IDX_W-1:0] fempty_idx_reg, fempty_idx_next;

    logic  um_found_reg, um_found_next;
    logic [USED_IDX_W-1:0] um_idx_reg, um_idx_next;
    logic  ue_found_reg, ue_found_next;
    logic [USED_IDX_W-1:0] ue_idx_reg, ue_idx_next;

    logic  mprev_reg, mprev_next;
    logic  mnext_reg, mnext_next;

    logic [ADDR_BITS:0]    round_sum;
    logic                  fv, uv;
    logic [FREE_IDX_W-1:0] pfi;
    logic [USED_IDX_W-1:0] pui;
    logic [USED_IDX_W-1:0] uslot;
    addr_t                 sum_a, sum_b;

    assign req_ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign round_sum = {1'b0, req.request_size} + (ADDR_BITS+1)'((1 << ALIGN_LOG2) - 1);
    assign pfi = pipe_idx_reg[FREE_IDX_W-1:0];
    assign pui = pipe_idx_reg[USED_IDX_W-1:0];
    assign fv  = free_valid_reg[pfi];
    assign uv  = used_valid_reg[pui];

    assign scan_active = (state_reg == S_ASCAN) || (state_reg == S_AUSED) ||
                         (state_reg == S_FUSED) || (state_reg == S_FSCAN);
    assign scan_limit  = ((state_reg == S_AUSED) || (state_reg == S_FUSED)) ?
                         SCAN_W'(USED_ENTRIES) : SCAN_W'(FREE_ENTRIES);
    assign scan_done   = (scan_idx_reg == scan_limit) && !pipe_vld_reg;

    // shared adders, one per step
    assign sum_a = prev_base_reg + prev_len_reg;
    assign sum_b = ptr_reg + total_reg;

    always_comb
    begin
        state_next        = state_reg;
        scan_idx_next     = scan_idx_reg;
        pipe_vld_next     = 1'b0;
        pipe_idx_next     = pipe_idx_reg;
        free_valid_next   = free_valid_reg;
        used_valid_next   = used_valid_reg;
        free_we           = 1'b0;
        free_waddr        = '0;
        free_wdata        = '0;
        used_we           = 1'b0;
        used_waddr        = '0;
        used_wdata        = '0;
        rsp_valid_next    = rsp_valid_reg && !rsp_ready;
        rsp_next          = rsp_reg;
        a_next            = a_reg;
        rounded_next      = rounded_reg;
        ulen_next         = ulen_reg;
        ptr_next          = ptr_reg;
        total_next        = total_reg;
        best_found_next   = best_found_reg;
        best_idx_next     = best_idx_reg;
        best_base_next    = best_base_reg;
        best_len_next     = best_len_reg;
        prev_found_next   = prev_found_reg;
        prev_idx_next     = prev_idx_reg;
        prev_base_next    = prev_base_reg;
        prev_len_next     = prev_len_reg;
        next_found_next   = next_found_reg;
        next_idx_next     = next_idx_reg;
        next_base_next    = next_base_reg;
        next_len_next     = next_len_reg;
        same_found_next   = same_found_reg;
        same_idx_next     = same_idx_reg;
        fempty_found_next = fempty_found_reg;
        fempty_idx_next   = fempty_idx_reg;
        um_found_next     = um_found_reg;
        um_idx_next       = um_idx_reg;
        ue_found_next     = ue_found_reg;
        ue_idx_next       = ue_idx_reg;
        mprev_next        = mprev_reg;
        mnext_next        = mnext_reg;
        uslot             = um_found_reg ? um_idx_reg : ue_idx_reg;

        if (scan_active && (scan_idx_reg < scan_limit))
        begin
            pipe_vld_next = 1'b1;
            pipe_idx_next = scan_idx_reg[IDX_W-1:0];
            scan_idx_next = scan_idx_reg + SCAN_W'(1);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    a_next            = req.block_addr;
                    rounded_next      = {round_sum[ADDR_BITS-1:ALIGN_LOG2],
                                         ALIGN_LOG2'(0)};
                    scan_idx_next     = '0;
                    best_found_next   = 1'b0;
                    prev_found_next   = 1'b0;
                    next_found_next   = 1'b0;
                    same_found_next   = 1'b0;
                    fempty_found_next = 1'b0;
                    um_found_next     = 1'b0;
                    ue_found_next     = 1'b0;
                    case (req.opcode)
                        OP_INIT:
                        begin
                            state_next = S_INIT;
                        end
                        OP_ALLOC:
                        begin
                            if (req.request_size == '0)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next       = mk_rsp(ST_BAD, '0, '0);
                            end
                            else if (round_sum[ADDR_BITS])
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next       = mk_rsp(ST_NOSPACE, '0, '0);
                            end
                            else
                            begin
                                state_next = S_ASCAN;
                            end
                        end
                        OP_FREE:
                        begin
                            state_next = S_FUSED;
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next       = mk_rsp(ST_BAD, '0, '0);
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                free_valid_next = '0;
                used_valid_next = '0;
                rsp_valid_next  = 1'b1;
                if (pool_len_reg != '0)
                begin
                    free_we            = 1'b1;
                    free_waddr         = '0;
                    free_wdata.base    = pool_base_reg;
                    free_wdata.len     = pool_len_reg;
                    free_valid_next[0] = 1'b1;
                    rsp_next           = mk_rsp(ST_OK, '0, '0);
                end
                else
                begin
                    rsp_next = mk_rsp(ST_BAD, '0, '0);
                end
                state_next = S_IDLE;
            end
            S_ASCAN:
            begin
                if (pipe_vld_reg && fv && (free_rd_reg.len >= rounded_reg) &&
                    (!best_found_reg || (free_rd_reg.base < best_base_reg)))
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = pfi;
                    best_base_next  = free_rd_reg.base;
                    best_len_next   = free_rd_reg.len;
                end
                if (scan_done)
                begin
                    if (!best_found_reg)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next       = mk_rsp(ST_NOSPACE, '0, '0);
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ACALC;
                    end
                end
            end
            S_ACALC:
            begin
                // equal sizes give zero remainder, so the chunk base
                a_next        = best_base_reg + (best_len_reg - rounded_reg);
                scan_idx_next = '0;
                state_next    = S_AUSED;
            end
            S_AUSED:
            begin
                if (pipe_vld_reg)
                begin
                    if (uv && (used_rd_reg.base == a_reg) && !um_found_reg)
                    begin
                        um_found_next = 1'b1;
                        um_idx_next   = pui;
                    end
                    if (!uv && !ue_found_reg)
                    begin
                        ue_found_next = 1'b1;
                        ue_idx_next   = pui;
                    end
                end
                if (scan_done)
                begin
                    if (!um_found_reg && !ue_found_reg)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next       = mk_rsp(ST_FULL, '0, '0);
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ACOMMIT;
                    end
                end
            end
            S_ACOMMIT:
            begin
                if (best_len_reg != rounded_reg)
                begin
                    free_we         = 1'b1;
                    free_waddr      = best_idx_reg;
                    free_wdata.base = best_base_reg;
                    free_wdata.len  = best_len_reg - rounded_reg;
                end
                else
                begin
                    free_valid_next[best_idx_reg] = 1'b0;
                end
                used_we                = 1'b1;
                used_waddr             = uslot;
                used_wdata.base        = a_reg;
                used_wdata.len         = rounded_reg;
                used_valid_next[uslot] = 1'b1;
                rsp_valid_next         = 1'b1;
                rsp_next               = mk_rsp(ST_OK, a_reg, rounded_reg);
                state_next             = S_IDLE;
            end
            S_FUSED:
            begin
                if (pipe_vld_reg && uv && (used_rd_reg.base == a_reg) && !um_found_reg)
                begin
                    um_found_next = 1'b1;
                    um_idx_next   = pui;
                    ulen_next     = used_rd_reg.len;
                end
                if (scan_done)
                begin
                    if (!um_found_reg)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next       = mk_rsp(ST_UNKNOWN, '0, '0);
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        scan_idx_next = '0;
                        state_next    = S_FSCAN;
                    end
                end
            end
            S_FSCAN:
            begin
                if (pipe_vld_reg)
                begin
                    if (fv)
                    begin
                        if (free_rd_reg.base <= a_reg)
                        begin
                            if (!prev_found_reg || (free_rd_reg.base > prev_base_reg))
                            begin
                                prev_found_next = 1'b1;
                                prev_idx_next   = pfi;
                                prev_base_next  = free_rd_reg.base;
                                prev_len_next   = free_rd_reg.len;
                            end
                        end
                        else if (!next_found_reg || (free_rd_reg.base < next_base_reg))
                        begin
                            next_found_next = 1'b1;
                            next_idx_next   = pfi;
                            next_base_next  = free_rd_reg.base;
                            next_len_next   = free_rd_reg.len;
                        end
                        if ((free_rd_reg.base == a_reg) && !same_found_reg)
                        begin
                            same_found_next = 1'b1;
                            same_idx_next   = pfi;
                        end
                    end
                    else if (!fempty_found_reg)
                    begin
                        fempty_found_next = 1'b1;
                        fempty_idx_next   = pfi;
                    end
                end
                if (scan_done)
                begin
                    state_next = S_FPREV;
                end
            end
            S_FPREV:
            begin
                mprev_next = prev_found_reg && (sum_a == a_reg);
                ptr_next   = (prev_found_reg && (sum_a == a_reg)) ? prev_base_reg : a_reg;
                total_next = (prev_found_reg && (sum_a == a_reg)) ?
                             (ulen_reg + prev_len_reg) : ulen_reg;
                state_next = S_FNEXT;
            end
            S_FNEXT:
            begin
                mnext_next = next_found_reg && (sum_b == next_base_reg);
                if (next_found_reg && (sum_b == next_base_reg))
                begin
                    total_next = total_reg + next_len_reg;
                end
                state_next = S_FCOMMIT;
            end
            S_FCOMMIT:
            begin
                state_next = S_IDLE;
                rsp_valid_next = 1'b1;
                if (!mprev_reg && !mnext_reg && !same_found_reg && !fempty_found_reg)
                begin
                    rsp_next = mk_rsp(ST_FULL, '0, '0);
                end
                else
                begin
                    free_we = 1'b1;
                    if (mprev_reg)
                    begin
                        free_waddr = prev_idx_reg;
                    end
                    else if (mnext_reg)
                    begin
                        free_waddr = next_idx_reg;
                    end
                    else if (same_found_reg)
                    begin
                        free_waddr = same_idx_reg;
                    end
                    else
                    begin
                        free_waddr = fempty_idx_reg;
                    end
                    free_wdata.base = ptr_reg;
                    free_wdata.len  = total_reg;
                    if (mprev_reg && mnext_reg)
                    begin
                        free_valid_next[next_idx_reg] = 1'b0;
                    end
                    free_valid_next[free_waddr] = 1'b1;
                    used_valid_next[um_idx_reg] = 1'b0;
                    rsp_next = mk_rsp(ST_OK, '0, ulen_reg);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // table memories, registered read at the scan index
    always_ff @(posedge clk)
    begin
        if (free_we)
        begin
            free_mem[free_waddr] <= free_wdata;
        end
        free_rd_reg <= free_mem[scan_idx_reg[FREE_IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (used_we)
        begin
            used_mem[used_waddr] <= used_wdata;
        end
        used_rd_reg <= used_mem[scan_idx_reg[USED_IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            pool_base_reg    <= '0;
            pool_len_reg     <= '0;
            free_valid_reg   <= '0;
            used_valid_reg   <= '0;
            scan_idx_reg     <= '0;
            pipe_vld_reg     <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            best_found_reg   <= 1'b0;
            prev_found_reg   <= 1'b0;
            next_found_reg   <= 1'b0;
            same_found_reg   <= 1'b0;
            fempty_found_reg <= 1'b0;
            um_found_reg     <= 1'b0;
            ue_found_reg     <= 1'b0;
            mprev_reg        <= 1'b0;
            mnext_reg        <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            free_valid_reg   <= free_valid_next;
            used_valid_reg   <= used_valid_next;
            scan_idx_reg     <= scan_idx_next;
            pipe_vld_reg     <= pipe_vld_next;
            rsp_valid_reg    <= rsp_valid_next;
            best_found_reg   <= best_found_next;
            prev_found_reg   <= prev_found_next;
            next_found_reg   <= next_found_next;
            same_found_reg   <= same_found_next;
            fempty_found_reg <= fempty_found_next;
            um_found_reg     <= um_found_next;
            ue_found_reg     <= ue_found_next;
            mprev_reg        <= mprev_next;
            mnext_reg        <= mnext_next;
            if (cfg_we && (cfg_idx == CFG_POOL_BASE))
            begin
                pool_base_reg <= cfg_data;
            end
            if (cfg_we && (cfg_idx == CFG_POOL_LEN))
            begin
                pool_len_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_idx_reg   <= pipe_idx_next;
        rsp_reg        <= rsp_next;
        a_reg          <= a_next;
        rounded_reg    <= rounded_next;
        ulen_reg       <= ulen_next;
        ptr_reg        <= ptr_next;
        total_reg      <= total_next;
        best_idx_reg   <= best_idx_next;
        best_base_reg  <= best_base_next;
        best_len_reg   <= best_len_next;
        prev_idx_reg   <= prev_idx_next;
        prev_base_reg  <= prev_base_next;
        prev_len_reg   <= prev_len_next;
        next_idx_reg   <= next_idx_next;
        next_base_reg  <= next_base_next;
        next_len_reg   <= next_len_next;
        same_idx_reg   <= same_idx_next;
        fempty_idx_reg <= fempty_idx_next;
        um_idx_reg     <= um_idx_next;
        ue_idx_reg     <= ue_idx_next;
    end

    `FFCA_ASSERT(a_single_item, (req_valid && req_ready) |=> !req_ready)
    `FFCA_NEVER(a_rsp_while_busy, rsp_valid_reg && (state_reg != S_IDLE))
    `FFCA_NEVER(a_ok_aligned, rsp_valid_reg && (rsp_reg.status == ST_OK) && (rsp_reg.granted_size[ALIGN_LOG2-1:0] != '0))

endmodule
`default_nettype wire

// File: tb/first_fit_coalescing_allocator_unit_tb.sv
// self-checking testbench for the first-fit coalescing allocator unit
// depends on ffca_pkg and first_fit_coalescing_allocator_unit; a scoreboard class
// carries its own model of the free and used tables
`default_nettype none

module first_fit_coalescing_allocator_unit_tb
    import ffca_pkg::*;
();

    class alloc_scoreboard;
        addr_t base_reg;
        addr_t size_reg;
        addr_t fbase [FREE_ENTRIES];
        addr_t flen  [FREE_ENTRIES];
        bit    fval  [FREE_ENTRIES];
        addr_t ubase [USED_ENTRIES];
        addr_t ulen  [USED_ENTRIES];
        bit    uval  [USED_ENTRIES];
        rsp_t  pending_rsp[$];
        int    errors;

        function new();
            base_reg = '0;
            size_reg = '0;
            errors = 0;
            clear_tables();
        endfunction

        function void clear_tables();
            for (int i = 0; i < FREE_ENTRIES; i++)
            begin
                fbase[i] = '0;
                flen[i] = '0;
                fval[i] = 0;
            end
            for (int i = 0; i < USED_ENTRIES; i++)
            begin
                ubase[i] = '0;
                ulen[i] = '0;
                uval[i] = 0;
            end
        endfunction

        function void write_reg(logic idx, addr_t v);
            if (idx == CFG_POOL_BASE)
                base_reg = v;
            else
                size_reg = v;
        endfunction

        function int used_lookup(addr_t a);
            for (int i = 0; i < USED_ENTRIES; i++)
                if (uval[i] && ubase[i] == a)
                    return i;
            return -1;
        endfunction

        function int used_hole();
            for (int i = 0; i < USED_ENTRIES; i++)
                if (!uval[i])
                    return i;
            return -1;
        endfunction

        function int free_lookup(addr_t a);
            for (int i = 0; i < FREE_ENTRIES; i++)
                if (fval[i] && fbase[i] == a)
                    return i;
            return -1;
        endfunction

        function int free_hole();
            for (int i = 0; i < FREE_ENTRIES; i++)
                if (!fval[i])
                    return i;
            return -1;
        endfunction

        function rsp_t allocate(addr_t reqsz);
            logic [ADDR_BITS:0] rounded;
            addr_t len;
            addr_t a;
            int best;
            int u;
            best = -1;
            if (reqsz == 0)
                return mk_rsp(ST_BAD, '0, '0);
            rounded = ({1'b0, reqsz} + 63) & ~(49'd63);
            if (rounded[ADDR_BITS])
                return mk_rsp(ST_NOSPACE, '0, '0);
            for (int i = 0; i < FREE_ENTRIES; i++)
                if (fval[i] && flen[i] >= rounded[ADDR_BITS-1:0] &&
                    (best < 0 || fbase[i] < fbase[best]))
                    best = i;
            if (best < 0)
                return mk_rsp(ST_NOSPACE, '0, '0);
            len = flen[best];
            if (len > rounded[ADDR_BITS-1:0])
                a = fbase[best] + len - rounded[ADDR_BITS-1:0];
            else
                a = fbase[best];
            u = used_lookup(a);
            if (u < 0)
                u = used_hole();
            if (u < 0)
                return mk_rsp(ST_FULL, '0, '0);
            if (len > rounded[ADDR_BITS-1:0])
                flen[best] = len - rounded[ADDR_BITS-1:0];
            else
                fval[best] = 0;
            ubase[u] = a;
            ulen[u] = rounded[ADDR_BITS-1:0];
            uval[u] = 1;
            return mk_rsp(ST_OK, a, rounded[ADDR_BITS-1:0]);
        endfunction

        function rsp_t release_block(addr_t a);
            addr_t len;
            addr_t ptr;
            addr_t total;
            int u;
            int prv;
            int nxt;
            int slot;
            bit mprev;
            bit mnext;
            prv = -1;
            nxt = -1;
            u = used_lookup(a);
            if (u < 0)
                return mk_rsp(ST_UNKNOWN, '0, '0);
            len = ulen[u];
            for (int i = 0; i < FREE_ENTRIES; i++)
            begin
                if (!fval[i])
                    continue;
                if (fbase[i] <= a)
                begin
                    if (prv < 0 || fbase[i] > fbase[prv])
                        prv = i;
                end
                else if (nxt < 0 || fbase[i] < fbase[nxt])
                    nxt = i;
            end
            ptr = a;
            total = len;
            mprev = prv >= 0 && (fbase[prv] + flen[prv]) == a;
            if (mprev)
            begin
                total = total + flen[prv];
                ptr = fbase[prv];
            end
            mnext = nxt >= 0 && (ptr + total) == fbase[nxt];
            if (mnext)
                total = total + flen[nxt];
            if (mprev)
                slot = prv;
            else if (mnext)
                slot = nxt;
            else
            begin
                slot = free_lookup(ptr);
                if (slot < 0)
                    slot = free_hole();
            end
            if (slot < 0)
                return mk_rsp(ST_FULL, '0, '0);
            uval[u] = 0;
            if (mprev && mnext)
                fval[nxt] = 0;
            fbase[slot] = ptr;
            flen[slot] = total;
            fval[slot] = 1;
            return mk_rsp(ST_OK, '0, len);
        endfunction

        function void note_request(req_t r);
            rsp_t e;
            case (r.opcode)
                OP_INIT:
                begin
                    clear_tables();
                    if (size_reg == 0)
                        e = mk_rsp(ST_BAD, '0, '0);
                    else
                    begin
                        fbase[0] = base_reg;
                        flen[0] = size_reg;
                        fval[0] = 1;
                        e = mk_rsp(ST_OK, '0, '0);
                    end
                end
                OP_ALLOC: e = allocate(r.request_size);
                OP_FREE:  e = release_block(r.block_addr);
                default:  e = mk_rsp(ST_BAD, '0, '0);
            endcase
            pending_rsp = {pending_rsp, e};
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_response(rsp_t got);
            rsp_t e;
            if (pending_rsp.size() == 0)
            begin
                report($sformatf("unexpected response %h", got));
                return;
            end
            e = pending_rsp.pop_front();
            if (got.status !== e.status)
                report($sformatf("status %0d want %0d", got.status, e.status));
            if (got.result_addr !== e.result_addr)
                report($sformatf("addr %h want %h", got.result_addr, e.result_addr));
            if (got.granted_size !== e.granted_size)
                report($sformatf("size %h want %h", got.granted_size, e.granted_size));
        endtask

        // returns a random live block start, or a random address when none
        function addr_t some_block();
            int live[$];
            for (int i = 0; i < USED_ENTRIES; i++)
                if (uval[i])
                    live = {live, i};
            if (live.size() == 0)
                return addr_t'({$urandom, $urandom}) & 48'hFFFF_FFFF_FFC0;
            return ubase[live[$urandom_range(live.size() - 1)]];
        endfunction
    endclass

    localparam int LIMIT_CYCLES = 2000000;

    logic  clk;
    logic  rst_n;
    logic  cfg_we;
    logic  cfg_idx;
    addr_t cfg_data;
    logic  req_valid;
    logic  req_ready;
    req_t  req;
    logic  rsp_valid;
    logic  rsp_ready;
    rsp_t  rsp;

    alloc_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    longint cycles;

    first_fit_coalescing_allocator_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_data(cfg_data), .req_valid(req_valid), .req_ready(req_ready),
        .req(req), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("first_fit_coalescing_allocator_unit_tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp);

    // receiver stalls; a long hold-off is counted here
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic addr_t rand_addr();
        return addr_t'({$urandom, $urandom});
    endfunction

    task automatic send(req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(r);
        @(negedge clk);
    endtask

    task automatic do_op(logic [1:0] op, addr_t sz, addr_t a);
        req_t r;
        r.opcode = op;
        r.request_size = sz;
        r.block_addr = a;
        send(r);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending_rsp.size() != 0)
            @(negedge clk);
        repeat (200)
            @(negedge clk);
    endtask

    task automatic write_reg(logic idx, addr_t v);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= v;
        sb.write_reg(idx, v);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic addr_t rand_size();
        case ($urandom_range(9))
            0: return rand_addr();
            1: return addr_t'($urandom_range(1, 64));
            2: return 48'd64 * addr_t'($urandom_range(1, 8));
            default: return addr_t'($urandom_range(1, 2048));
        endcase
    endfunction

    task automatic random_phase(int n, int sidle, int rstall);
        int k;
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(19))
                0: do_op(OP_INIT, rand_addr(), rand_addr());
                1: do_op(OP_RESERVED, rand_addr(), rand_addr());
                2, 3: do_op(OP_FREE, rand_size(), rand_addr());
                4, 5, 6, 7, 8, 9, 10: do_op(OP_FREE, rand_addr(), sb.some_block());
                default: do_op(OP_ALLOC, rand_size(), rand_addr());
            endcase
        end
        drain();
    endtask

    initial
    begin
        addr_t b;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_POOL_BASE;
        cfg_data = '0;
        req_valid = 1'b0;
        req = '0;
        rsp_ready = 1'b0;
        hold_cycles = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sb = new();
        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty pool, alloc with no space, unknown free, bad opcode
        do_op(OP_INIT, '0, '0);
        do_op(OP_ALLOC, 48'd64, '0);
        do_op(OP_FREE, '0, 48'h1000);
        do_op(OP_RESERVED, '1, '1);
        drain();
        write_reg(CFG_POOL_BASE, 48'h1000);
        write_reg(CFG_POOL_LEN, 48'h1000);
        do_op(OP_INIT, '0, '0);
        do_op(OP_ALLOC, '0, '0);
        do_op(OP_ALLOC, '1, '0);
        do_op(OP_ALLOC, 48'd1, '0);
        do_op(OP_ALLOC, 48'd65, '0);
        do_op(OP_ALLOC, 48'd64, '0);
        do_op(OP_FREE, '0, 48'h1F80);
        do_op(OP_FREE, '0, 48'h1F40);
        do_op(OP_FREE, '0, 48'h1FC0);
        do_op(OP_ALLOC, 48'h1000, '0);
        do_op(OP_FREE, '0, 48'h1000);
        do_op(OP_FREE, '0, 48'h1000);
        drain();
        // wrap at the top of the address range
        write_reg(CFG_POOL_BASE, 48'hFFFF_FFFF_FF00);
        write_reg(CFG_POOL_LEN, 48'h200);
        do_op(OP_INIT, '0, '0);
        do_op(OP_ALLOC, 48'h100, '0);
        do_op(OP_ALLOC, 48'h100, '0);
        do_op(OP_FREE, '0, 48'h0);
        do_op(OP_FREE, '0, 48'hFFFF_FFFF_FF00);
        drain();
        // fill the used table to force table full
        write_reg(CFG_POOL_BASE, '0);
        write_reg(CFG_POOL_LEN, 48'h10000);
        do_op(OP_INIT, '0, '0);
        for (int i = 0; i < 66; i++)
            do_op(OP_ALLOC, 48'd64, '0);
        drain();
        // fragment the free table: free every other block
        for (int i = 0; i < 64; i += 2)
            do_op(OP_FREE, '0, 48'h10000 - 48'd64 * (i + 1));
        drain();

        write_reg(CFG_POOL_LEN, '1 & 48'hFFFF_FFFF_FFC0);
        do_op(OP_INIT, '0, '0);
        random_phase(150, 0, 0);
        b = rand_addr() & 48'hFFFF_FFFF_FFC0;
        write_reg(CFG_POOL_BASE, b);
        write_reg(CFG_POOL_LEN, 48'h4000);
        do_op(OP_INIT, '0, '0);
        random_phase(150, 70, 0);
        write_reg(CFG_POOL_BASE, '1 & 48'hFFFF_FFFF_FFC0);
        write_reg(CFG_POOL_LEN, 48'h2000);
        do_op(OP_INIT, '0, '0);
        random_phase(150, 0, 70);
        write_reg(CFG_POOL_BASE, 48'h40);
        write_reg(CFG_POOL_LEN, 48'h1000);
        do_op(OP_INIT, '0, '0);
        random_phase(150, 34, 34);
        // long receiver hold-off while requests keep coming
        hold_cycles = 600;
        random_phase(40, 0, 0);
        random_phase(50, 0, 0);

        if (sb.errors == 0)
            $display("first_fit_coalescing_allocator_unit_tb: PASS");
        else
            $display("first_fit_coalescing_allocator_unit_tb: FAIL");
        $finish;
    end
endmodule

`default_nettype wire
